/* rtl/swdhte_pkg.sv */
// Shared types, codes and helper functions for the SWD host transaction engine.
// No dependencies; the engine unit in rtl/ imports this package.
package swdhte_pkg;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_HIGH = 1'b1;

  // Request kinds carried by each SWCLK period.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_WRITE   = 2'd2;
  localparam logic [1:0] KIND_CONNECT = 2'd3;

  // Status codes reported on every result.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_WAIT    = 2'd1;
  localparam logic [1:0] ST_FAULT   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Acknowledge patterns in arrival order, first bit received in the MSB.
  localparam logic [2:0] ACK_OK    = 3'b100;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b001;

  // JTAG-to-SWD select code, sent MSB first.
  localparam logic [15:0] SWD_SELECT_SEQ = 16'h79E7;

  // Line reset length limits and reset values of the registers.
  localparam logic [5:0] RESET_HIGH_MIN = 6'd50;
  localparam logic [5:0] RESET_HIGH_DEF = 6'd51;
  localparam logic [2:0] TRN_DEF        = 3'd1;
  localparam logic [2:0] TRN_MIN        = 3'd1;
  localparam logic [2:0] TRN_MAX        = 3'd4;

  // Latched request: bit 0 APnDP, bit 1 RnW, bit 2 A2, bit 3 A3.
  localparam logic [3:0] REQ_IDCODE = 4'b0010;

  // Protocol phase, one-hot coded.
  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_REQ    = 9'b000000010,
    PH_TRN1   = 9'b000000100,
    PH_ACK    = 9'b000001000,
    PH_TRN2   = 9'b000010000,
    PH_WDATA  = 9'b000100000,
    PH_RDATA  = 9'b001000000,
    PH_LRESET = 9'b010000000,
    PH_JTAG   = 9'b100000000
  } phase_t;

  // Even parity of a 32-bit word.
  function automatic logic parity32(input logic [31:0] v);
    return ^v;
  endfunction

  // Level of bit i of the 8-bit request header (idle bit at position 0).
  function automatic logic request_bit(input logic [5:0] i, input logic [3:0] r);
    logic b;
    b = 1'b0;
    case (i)
      6'd1:    b = 1'b1;
      6'd2:    b = r[0];
      6'd3:    b = r[1];
      6'd4:    b = r[2];
      6'd5:    b = r[3];
      6'd6:    b = ^r;
      6'd8:    b = 1'b1;
      default: b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

/* rtl/swdhte_if.sv */
// Valid/ready channel interfaces for the SWD host transaction engine.
// Command channel carries one SWCLK period; response channel carries its result.
// No dependencies.
interface swdhte_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        ap_not_dp;
  logic [1:0]  reg_addr;
  logic [31:0] write_word;
  logic        line_in;

  modport source (output valid, kind, ap_not_dp, reg_addr, write_word, line_in,
                  input ready);
  modport sink (input valid, kind, ap_not_dp, reg_addr, write_word, line_in,
                output ready);
endinterface

interface swdhte_rsp_if;
  logic        valid;
  logic        ready;
  logic        line_out;
  logic        line_drive;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;
  logic [31:0] read_word;
  logic        parity_error;

  modport source (output valid, line_out, line_drive, busy_res, done_res, status,
                  read_word, parity_error, input ready);
  modport sink (input valid, line_out, line_drive, busy_res, done_res, status,
                read_word, parity_error, output ready);
endinterface

/* rtl/swd_host_transaction_engine_unit.sv */
// SWD host transaction engine: one request per SWCLK period, one response each.
// The response is registered on the clock edge that accepts its request.
// Throughput: one request per cycle unless a held response is not taken; the response register frees as it is taken.
// Reset (rst, synchronous, active high): idle phase, counters and latched ack,
// read data and status cleared, turnaround 1 and line reset length 51.
// Depends on swdhte_pkg and the channel interfaces in swdhte_if.sv.
module swd_host_transaction_engine_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swdhte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swdhte_pkg::CFG_DATA_W-1:0]   cfg_data,
  swdhte_cmd_if.sink                          cmd,
  swdhte_rsp_if.source                        rsp
);
  import swdhte_pkg::*;

  // Configuration registers.
  logic [2:0] turnaround_cycles;
  logic [5:0] reset_high_bits;

  // Protocol state.
  phase_t      phase, phase_next;
  logic [5:0]  bit_count, bit_count_next;
  logic [32:0] shift_word, shift_word_next;
  logic [3:0]  request_latch, request_latch_next;
  logic [2:0]  ack_bits, ack_bits_next;
  logic        parity_acc, parity_acc_next;
  logic [1:0]  connect_step, connect_step_next;
  logic [31:0] last_read, last_read_next;
  logic [1:0]  last_status, last_status_next;
  logic        last_perr, last_perr_next;

  // Response register.
  logic        out_valid;
  logic        out_line_out, out_line_drive, out_busy, out_done;
  logic [1:0]  out_status;
  logic [31:0] out_read_word;
  logic        out_perr;

  // Per-period line outputs.
  logic        lo, drive, busy, done;
  logic        accept;
  logic [2:0]  trn_len;
  logic [5:0]  high_len;
  logic        trn_last;
  logic [2:0]  ack_shift;
  logic [1:0]  ack_status;

  assign accept    = cmd.valid & cmd.ready;
  assign cmd.ready = ~out_valid | rsp.ready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      turnaround_cycles <= TRN_DEF;
      reset_high_bits   <= RESET_HIGH_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TURNAROUND: turnaround_cycles <= cfg_data[2:0];
        CFG_RESET_HIGH: reset_high_bits   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the register values to their legal ranges; also find the last turnaround period and decode the acknowledge.
  always_comb begin
    if (turnaround_cycles < TRN_MIN) begin
      trn_len = TRN_MIN;
    end else if (turnaround_cycles > TRN_MAX) begin
      trn_len = TRN_MAX;
    end else begin
      trn_len = turnaround_cycles;
    end
    high_len  = (reset_high_bits < RESET_HIGH_MIN) ? RESET_HIGH_MIN : reset_high_bits;
    trn_last  = ({1'b0, bit_count} + 7'd1) >= {4'b0000, trn_len};
    ack_shift = {ack_bits[1:0], cmd.line_in};
    case (ack_shift)
      ACK_OK:    ack_status = ST_OK;
      ACK_WAIT:  ack_status = ST_WAIT;
      ACK_FAULT: ack_status = ST_FAULT;
      default:   ack_status = ST_INVALID;
    endcase
  end

  // One SWCLK period of the protocol sequencer.
  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_word_next    = shift_word;
    request_latch_next = request_latch;
    ack_bits_next      = ack_bits;
    parity_acc_next    = parity_acc;
    connect_step_next  = connect_step;
    last_read_next     = last_read;
    last_status_next   = last_status;
    last_perr_next     = last_perr;
    lo    = 1'b0;
    drive = 1'b1;
    busy  = 1'b1;
    done  = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        case (cmd.kind)
          KIND_READ, KIND_WRITE: begin
            request_latch_next = {cmd.reg_addr, cmd.kind == KIND_READ, cmd.ap_not_dp};
            if (cmd.kind == KIND_WRITE) begin
              shift_word_next = {parity32(cmd.write_word), cmd.write_word};
            end
            phase_next     = PH_REQ;
            bit_count_next = 6'd1;
          end
          KIND_CONNECT: begin
            lo                = 1'b1;
            connect_step_next = 2'd0;
            phase_next        = PH_LRESET;
            bit_count_next    = 6'd1;
          end
          default: begin
            busy = 1'b0;
          end
        endcase
      end

      // Request header: start, APnDP, RnW, A2, A3, parity, stop, park.
      PH_REQ: begin
        lo = request_bit(bit_count, request_latch);
        if (bit_count >= 6'd8) begin
          phase_next     = PH_TRN1;
          bit_count_next = 6'd0;
        end else begin
          bit_count_next = bit_count + 6'd1;
        end
      end

      PH_TRN1: begin
        drive = 1'b0;
        if (trn_last) begin
          phase_next     = PH_ACK;
          bit_count_next = 6'd0;
          ack_bits_next  = 3'b000;
        end else begin
          bit_count_next = bit_count + 6'd1;
        end
      end

      // Three acknowledge bits; an ok read goes to the data phase.
      PH_ACK: begin
        drive         = 1'b0;
        ack_bits_next = ack_shift;
        if (bit_count >= 6'd2) begin
          last_status_next = ack_status;
          bit_count_next   = 6'd0;
          if (ack_status == ST_OK && request_latch[1]) begin
            phase_next      = PH_RDATA;
            shift_word_next = '0;
            parity_acc_next = 1'b0;
          end else begin
            phase_next = PH_TRN2;
          end
        end else begin
          bit_count_next = bit_count + 6'd1;
        end
      end

      // Read data LSB first, then its parity bit.
      PH_RDATA: begin
        drive = 1'b0;
        if (bit_count < 6'd32) begin
          shift_word_next[bit_count] = cmd.line_in;
          parity_acc_next            = parity_acc ^ cmd.line_in;
          bit_count_next             = bit_count + 6'd1;
        end else begin
          last_perr_next = parity_acc ^ cmd.line_in;
          last_read_next = shift_word[31:0];
          phase_next     = PH_TRN2;
          bit_count_next = 6'd0;
        end
      end

      PH_TRN2: begin
        drive = 1'b0;
        if (trn_last) begin
          bit_count_next = 6'd0;
          if (last_status == ST_OK && !request_latch[1]) begin
            phase_next = PH_WDATA;
          end else begin
            done              = 1'b1;
            phase_next        = PH_IDLE;
            connect_step_next = 2'd0;
          end
        end else begin
          bit_count_next = bit_count + 6'd1;
        end
      end

      // Write data LSB first, parity bit last.
      PH_WDATA: begin
        lo = shift_word[bit_count];
        if (bit_count >= 6'd32) begin
          done              = 1'b1;
          phase_next        = PH_IDLE;
          bit_count_next    = 6'd0;
          connect_step_next = 2'd0;
        end else begin
          bit_count_next = bit_count + 6'd1;
        end
      end

      // Line reset: high periods, then one low period.
      PH_LRESET: begin
        if (bit_count < high_len) begin
          lo             = 1'b1;
          bit_count_next = bit_count + 6'd1;
        end else begin
          bit_count_next = 6'd0;
          if (connect_step == 2'd0) begin
            connect_step_next = 2'd1;
            phase_next        = PH_JTAG;
          end else begin
            connect_step_next  = 2'd3;
            request_latch_next = REQ_IDCODE;
            phase_next         = PH_REQ;
          end
        end
      end

      PH_JTAG: begin
        lo = SWD_SELECT_SEQ[4'd15 - bit_count[3:0]];
        if (bit_count >= 6'd15) begin
          connect_step_next = 2'd2;
          phase_next        = PH_LRESET;
          bit_count_next    = 6'd0;
        end else begin
          bit_count_next = bit_count + 6'd1;
        end
      end

      default: begin
        phase_next     = PH_IDLE;
        bit_count_next = 6'd0;
        busy           = 1'b0;
      end
    endcase

    if (!drive) begin
      lo = 1'b0;
    end
  end

  // State advances once per accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      shift_word    <= '0;
      request_latch <= '0;
      ack_bits      <= '0;
      parity_acc    <= 1'b0;
      connect_step  <= '0;
      last_read     <= '0;
      last_status   <= ST_OK;
      last_perr     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_word    <= shift_word_next;
      request_latch <= request_latch_next;
      ack_bits      <= ack_bits_next;
      parity_acc    <= parity_acc_next;
      connect_step  <= connect_step_next;
      last_read     <= last_read_next;
      last_status   <= last_status_next;
      last_perr     <= last_perr_next;
    end
  end

  // Response register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Response payload, loaded with each accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_line_out   <= lo;
      out_line_drive <= drive;
      out_busy       <= busy;
      out_done       <= done;
      out_status     <= last_status_next;
      out_read_word  <= last_read_next;
      out_perr       <= last_perr_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.line_out     = out_line_out;
  assign rsp.line_drive   = out_line_drive;
  assign rsp.busy_res     = out_busy;
  assign rsp.done_res     = out_done;
  assign rsp.status       = out_status;
  assign rsp.read_word    = out_read_word;
  assign rsp.parity_error = out_perr;

endmodule
